>>> hdl/deq_pkg.sv
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_DUMP_FWD   = 3'd4,
        MODE_DUMP_BWD   = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

endpackage

>>> hdl/deq_ram.sv
module deq_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [deq_pkg::DATA_W-1:0] wdata,
    input  logic                              re,
    input  logic [AW-1:0]                     raddr,
    output logic signed [deq_pkg::DATA_W-1:0] rdata
);

    logic signed [deq_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/double_ended_queue.sv
// Bounded deque of signed 32-bit values held in a ring of DEPTH slots.
// Input channel s_*: s_tuser carries the operation (push front, push back,
// pop front, pop back, dump forward, dump backward), s_tdata the value to push.
// Output channel m_*: m_tuser carries the status (ok, empty, full), m_tdata
// the dumped element (zero otherwise), m_tlast marks the final result of an item.
// Push, pop and empty reports give one result, registered the cycle after the
// item is accepted; with m_tready high one such item is taken every cycle.
// A dump of N stored elements gives N results: the single read port of the
// slot memory (registered read) streams one element per cycle while m_tready
// is high, and no item is accepted until its last result has been taken.
// Undefined operation codes are accepted and dropped.
// Reset (rst_n low) empties the deque; slot contents are not cleared, since
// only occupied slots are ever read. When m_tready is low the result holds in
// the output register, the dump read stream pauses and s_tready drops.
module double_ended_queue #(
    parameter int DEPTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic signed [deq_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
    input  logic [deq_pkg::MODE_W-1:0]        s_tuser,  // [2:0] mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [deq_pkg::DATA_W-1:0] m_tdata,  // [31:0] element
    output logic [deq_pkg::STAT_W-1:0]        m_tuser,  // [1:0] status
    output logic                              m_tlast   // last result of the item
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::state_t                   state_reg, state_next;
    logic [IW-1:0]                     front_reg, front_next;
    logic [CW-1:0]                     occ_reg, occ_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic                              dir_reg, dir_next;
    logic                              pend_reg, pend_next;
    logic                              pend_last_reg, pend_last_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    deq_pkg::status_t                  m_status_reg, m_status_next;
    logic signed [deq_pkg::DATA_W-1:0] m_elem_reg, m_elem_next;
    logic                              m_last_reg, m_last_next;

    deq_pkg::mode_t                    mode;
    logic                              out_free;
    logic                              accept;
    logic                              full;
    logic                              empty;
    logic [IW-1:0]                     front_dec;
    logic [IW-1:0]                     front_inc;
    logic [IW-1:0]                     back_addr;
    logic [CW-1:0]                     rd_off;
    logic [IW-1:0]                     rd_addr;
    logic                              move;
    logic                              issue;
    logic                              issue_last;
    logic                              mem_we;
    logic [IW-1:0]                     mem_waddr;
    logic signed [deq_pkg::DATA_W-1:0] mem_rdata;

    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign mode       = deq_pkg::mode_t'(s_tuser);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == deq_pkg::S_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign full       = (occ_reg == CW'(DEPTH));
    assign empty      = (occ_reg == '0);
    assign front_dec  = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc  = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign back_addr  = ring_add(front_reg, occ_reg);
    assign rd_off     = dir_reg ? (occ_reg - 1'b1 - cnt_reg) : cnt_reg;
    assign rd_addr    = ring_add(front_reg, rd_off);
    assign move       = pend_reg && out_free;
    assign issue      = (state_reg == deq_pkg::S_DUMP) && (cnt_reg != occ_reg)
                        && (!pend_reg || move);
    assign issue_last = ((cnt_reg + 1'b1) == occ_reg);
    assign mem_we     = accept && !full
                        && (mode == deq_pkg::MODE_PUSH_FRONT
                            || mode == deq_pkg::MODE_PUSH_BACK);
    assign mem_waddr  = (mode == deq_pkg::MODE_PUSH_FRONT) ? front_dec : back_addr;

    deq_ram #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_tdata),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (accept && !empty
                    && (mode == deq_pkg::MODE_DUMP_FWD || mode == deq_pkg::MODE_DUMP_BWD))
                begin
                    state_next = deq_pkg::S_DUMP;
                end
            end
            deq_pkg::S_DUMP:
            begin
                if (move && pend_last_reg)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        front_next     = front_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        dir_next       = dir_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_status_next  = m_status_reg;
        m_elem_next    = m_elem_reg;
        m_last_next    = m_last_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (accept)
        begin
            unique case (mode)
                deq_pkg::MODE_PUSH_FRONT,
                deq_pkg::MODE_PUSH_BACK:
                begin
                    m_tvalid_next = 1'b1;
                    m_elem_next   = '0;
                    m_last_next   = 1'b1;
                    if (full)
                    begin
                        m_status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        m_status_next = deq_pkg::ST_OK;
                        occ_next      = occ_reg + 1'b1;
                        if (mode == deq_pkg::MODE_PUSH_FRONT)
                        begin
                            front_next = front_dec;
                        end
                    end
                end
                deq_pkg::MODE_POP_FRONT,
                deq_pkg::MODE_POP_BACK:
                begin
                    m_tvalid_next = 1'b1;
                    m_elem_next   = '0;
                    m_last_next   = 1'b1;
                    if (empty)
                    begin
                        m_status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        m_status_next = deq_pkg::ST_OK;
                        occ_next      = occ_reg - 1'b1;
                        if (mode == deq_pkg::MODE_POP_FRONT)
                        begin
                            front_next = front_inc;
                        end
                    end
                end
                deq_pkg::MODE_DUMP_FWD,
                deq_pkg::MODE_DUMP_BWD:
                begin
                    if (empty)
                    begin
                        m_tvalid_next = 1'b1;
                        m_status_next = deq_pkg::ST_EMPTY;
                        m_elem_next   = '0;
                        m_last_next   = 1'b1;
                    end
                    else
                    begin
                        cnt_next = '0;
                        dir_next = (mode == deq_pkg::MODE_DUMP_BWD);
                    end
                end
                default:
                begin
                    // undefined operation: drop the item
                end
            endcase
        end

        // hand the read word to the output register
        if (move)
        begin
            m_tvalid_next = 1'b1;
            m_status_next = deq_pkg::ST_OK;
            m_elem_next   = mem_rdata;
            m_last_next   = pend_last_reg;
            pend_next     = 1'b0;
        end

        if (issue)
        begin
            pend_next      = 1'b1;
            pend_last_next = issue_last;
            cnt_next       = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            dir_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            dir_reg       <= dir_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_status_reg <= m_status_next;
        m_elem_reg   <= m_elem_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_elem_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
